FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the heartbeat supervisor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in one cycle implies the consequent in the same cycle.
`define LHS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define LHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/lhs_pkg.sv
// ----------------------------------------------------------------------------
// Link heartbeat supervisor package
// Types, codes and reset values shared by the supervisor modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lhs_pkg;

	localparam int TIME_W  = 32;
	localparam int CNT_W   = 8;
	localparam int IVL_W   = 16;
	localparam int KIND_W  = 2;
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W = 3;
	localparam int OUT_TDATA_W = 24;

	// Event kinds. The unused code is handled as a tick.
	localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PONG = 2'd2;

	// Link modes.
	localparam logic [MODE_W-1:0] MODE_SEARCHING = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LINKED    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ERROR     = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PING_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DETECT_TIMEOUT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_WINDOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_BACKOFF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BACKOFF = 3'd5;

	// Register reset values.
	localparam logic [IVL_W-1:0]  RST_PING_INTERVAL  = 16'd2000;
	localparam logic [TIME_W-1:0] RST_DETECT_TIMEOUT = 32'd30000;
	localparam logic [TIME_W-1:0] RST_STALE          = 32'd15000;
	localparam logic [TIME_W-1:0] RST_PROBE_WINDOW   = 32'd3000;
	localparam logic [TIME_W-1:0] RST_INIT_BACKOFF   = 32'd5000;
	localparam logic [TIME_W-1:0] RST_MAX_BACKOFF    = 32'd30000;

	typedef struct packed {
		logic [IVL_W-1:0]  ping_interval;
		logic [TIME_W-1:0] detect_timeout;
		logic [TIME_W-1:0] stale;
		logic [TIME_W-1:0] probe_window;
		logic [TIME_W-1:0] init_backoff;
		logic [TIME_W-1:0] max_backoff;
	} lhs_cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [TIME_W-1:0] last_ping;
		logic [TIME_W-1:0] last_rx;
		logic [TIME_W-1:0] entered;
		logic [CNT_W-1:0]  attempts;
		logic [CNT_W-1:0]  retries;
		logic [TIME_W-1:0] backoff;
	} lhs_state_t;

	typedef struct packed {
		logic              just_linked;
		logic [CNT_W-1:0]  retry_count;
		logic [CNT_W-1:0]  ping_count;
		logic [MODE_W-1:0] link_state;
		logic              send_ping;
	} lhs_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/lhs_step.sv
// ----------------------------------------------------------------------------
// Link heartbeat supervisor step
// Next-state and result logic for one event, purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module lhs_step (
	input  wire logic [lhs_pkg::KIND_W-1:0] kind,
	input  wire logic [lhs_pkg::TIME_W-1:0] now_ms,
	input  wire lhs_pkg::lhs_cfg_t          cfg,
	input  wire lhs_pkg::lhs_state_t        cur,
	output lhs_pkg::lhs_state_t             nxt,
	output lhs_pkg::lhs_result_t            res
);
	import lhs_pkg::*;

	always_comb begin
		logic [TIME_W-1:0] since_ping;
		logic [TIME_W-1:0] since_enter;
		logic [TIME_W-1:0] quiet;
		logic [TIME_W:0]   drop_at;
		logic [TIME_W:0]   doubled;
		logic              send;
		logic              linked_now;

		nxt        = cur;
		send       = 1'b0;
		linked_now = 1'b0;

		// Receive activity refreshes the receive time first.
		if (kind == KIND_BYTE || kind == KIND_PONG) begin
			nxt.last_rx = now_ms;
		end

		// A pong links a searching or failed link.
		if (kind == KIND_PONG && (cur.mode == MODE_SEARCHING || cur.mode == MODE_ERROR)) begin
			nxt.mode    = MODE_LINKED;
			nxt.entered = now_ms;
			nxt.retries = '0;
			nxt.backoff = cfg.init_backoff;
			linked_now  = 1'b1;
		end

		since_ping  = now_ms - cur.last_ping;
		since_enter = now_ms - cur.entered;
		quiet       = now_ms - nxt.last_rx;
		drop_at     = {1'b0, cfg.stale} + {1'b0, cfg.probe_window};
		doubled     = {cur.backoff, 1'b0};

		unique case (nxt.mode)
			MODE_SEARCHING: begin
				if (since_ping >= {{(TIME_W-IVL_W){1'b0}}, cfg.ping_interval}) begin
					send          = 1'b1;
					nxt.last_ping = now_ms;
					nxt.attempts  = cur.attempts + 1'b1;
				end
				if (since_enter >= cfg.detect_timeout) begin
					nxt.mode    = MODE_ERROR;
					nxt.entered = now_ms;
				end
			end
			MODE_LINKED: begin
				if (quiet >= cfg.stale) begin
					send          = 1'b1;
					nxt.last_ping = now_ms;
					if ({1'b0, quiet} >= drop_at) begin
						nxt.mode     = MODE_SEARCHING;
						nxt.entered  = now_ms;
						nxt.attempts = '0;
					end
				end
			end
			MODE_ERROR: begin
				if (since_enter >= cur.backoff) begin
					nxt.retries = cur.retries + 1'b1;
					if (doubled > {1'b0, cfg.max_backoff}) begin
						nxt.backoff = cfg.max_backoff;
					end else begin
						nxt.backoff = doubled[TIME_W-1:0];
					end
					nxt.mode     = MODE_SEARCHING;
					nxt.entered  = now_ms;
					nxt.attempts = '0;
				end
			end
			default: begin
				// Unused mode code: only the receive time moves.
			end
		endcase

		res.send_ping   = send;
		res.link_state  = nxt.mode;
		res.ping_count  = nxt.attempts;
		res.retry_count = nxt.retries;
		res.just_linked = linked_now;
	end

endmodule

`default_nettype wire

FILE: rtl/core/link_heartbeat_supervisor_top.sv
// ----------------------------------------------------------------------------
// Link heartbeat supervisor
// Tracks the health of a serial link from timestamped tick, byte and pong
// events and reports ping requests and the link state for every event.
// ----------------------------------------------------------------------------
// The supervisor takes one event item per clock while results are taken and
// returns exactly one result item per event, in order. An event is captured
// in an input register, the link state is advanced by a single pass of compare
// and update logic, and the result lands in an output register, so a new event
// can be accepted every cycle as long as results are taken. The link state
// register is the only loop: each event sees the state left by the one before
// it. When the master side stalls, the input register holds one more event
// and then the slave side stops accepting. Configuration writes are always
// accepted and take effect at once; write them only while no event is in
// flight. Time differences are taken modulo 2^32 on the event timestamps, so
// the timestamp may wrap freely.
`default_nettype none

`include "assert_macros.svh"

module link_heartbeat_supervisor_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,

	// Event items.
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// tdata: now_ms [31:0]
	input  wire logic [lhs_pkg::TIME_W-1:0]         s_axis_tdata,
	// tuser: kind [1:0]
	input  wire logic [lhs_pkg::KIND_W-1:0]         s_axis_tuser,

	// Result items.
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// tdata: send_ping [0], link_state [2:1], ping_count [10:3],
	//        retry_count [18:11], just_linked [19], zero [23:20]
	output logic [lhs_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,

	// Configuration writes.
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [lhs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lhs_pkg::TIME_W-1:0]         cfg_data
);
	import lhs_pkg::*;

	localparam int RES_W = $bits(lhs_result_t);

	lhs_cfg_t          cfg_q;
	lhs_state_t        state_q;
	lhs_state_t        state_nxt;
	lhs_result_t       res_nxt;
	lhs_result_t       res_q;

	logic              valid_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [TIME_W-1:0] now_s1;
	logic              out_valid_q;
	logic              adv_s1;

	// The input stage moves on when the output register is empty or drains.
	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign cfg_ready     = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ping_interval  <= RST_PING_INTERVAL;
			cfg_q.detect_timeout <= RST_DETECT_TIMEOUT;
			cfg_q.stale          <= RST_STALE;
			cfg_q.probe_window   <= RST_PROBE_WINDOW;
			cfg_q.init_backoff   <= RST_INIT_BACKOFF;
			cfg_q.max_backoff    <= RST_MAX_BACKOFF;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PING_INTERVAL:  cfg_q.ping_interval  <= cfg_data[IVL_W-1:0];
				REG_DETECT_TIMEOUT: cfg_q.detect_timeout <= cfg_data;
				REG_STALE:          cfg_q.stale          <= cfg_data;
				REG_PROBE_WINDOW:   cfg_q.probe_window   <= cfg_data;
				REG_INIT_BACKOFF:   cfg_q.init_backoff   <= cfg_data;
				REG_MAX_BACKOFF:    cfg_q.max_backoff    <= cfg_data;
				default: begin
					// Writes beyond the register list are dropped.
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			kind_s1 <= s_axis_tuser;
			now_s1  <= s_axis_tdata;
		end
	end

	// One event worth of link supervision.
	lhs_step u_step (
		.kind   (kind_s1),
		.now_ms (now_s1),
		.cfg    (cfg_q),
		.cur    (state_q),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	// Link state advances only when an event moves into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode      <= MODE_SEARCHING;
			state_q.last_ping <= '0;
			state_q.last_rx   <= '0;
			state_q.entered   <= '0;
			state_q.attempts  <= '0;
			state_q.retries   <= '0;
			state_q.backoff   <= RST_INIT_BACKOFF;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, res_q};

	// A held event keeps its timestamp until it moves on.
	`LHS_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv_s1, valid_s1 && $stable(now_s1),
		"input stage lost a stalled event")
	// The link state never moves without an event being processed.
	`LHS_ASSERT_NEXT(a_state_quiet, !adv_s1, $stable(state_q),
		"link state changed without an event")
	// Every processed event produces a result in the next cycle.
	`LHS_ASSERT_NEXT(a_result_made, adv_s1, m_axis_tvalid,
		"processed event produced no result")
	// The input side is only blocked by a waiting result.
	`LHS_ASSERT_SAME(a_ready_cause, !s_axis_tready, valid_s1 && out_valid_q && !m_axis_tready,
		"input blocked without a stalled result")

endmodule

`default_nettype wire

FILE: sim/link_tracker_pkg.sv
// ----------------------------------------------------------------------------
// Link supervisor tracker
// Mirrors the heartbeat supervisor's link state per event and checks the
// result items that the block returns against the ones it worked out.
// ----------------------------------------------------------------------------
package link_tracker_pkg;

	import lhs_pkg::*;

	localparam int REPORT_W = $bits(lhs_result_t);

	class link_tracker;

		// Register copies.
		logic [IVL_W-1:0]  ping_gap;
		logic [TIME_W-1:0] search_limit;
		logic [TIME_W-1:0] quiet_limit;
		logic [TIME_W-1:0] grace;
		logic [TIME_W-1:0] first_wait;
		logic [TIME_W-1:0] wait_cap;

		// Link state copies.
		logic [MODE_W-1:0] mode;
		logic [TIME_W-1:0] ping_at;
		logic [TIME_W-1:0] heard_at;
		logic [TIME_W-1:0] since;
		logic [CNT_W-1:0]  pings;
		logic [CNT_W-1:0]  retries;
		logic [TIME_W-1:0] wait_now;

		lhs_result_t       reports_due[$];
		int unsigned       fail_count;
		int unsigned       results_seen;

		function new();
			ping_gap     = RST_PING_INTERVAL;
			search_limit = RST_DETECT_TIMEOUT;
			quiet_limit  = RST_STALE;
			grace        = RST_PROBE_WINDOW;
			first_wait   = RST_INIT_BACKOFF;
			wait_cap     = RST_MAX_BACKOFF;
			mode         = MODE_SEARCHING;
			ping_at      = '0;
			heard_at     = '0;
			since        = '0;
			pings        = '0;
			retries      = '0;
			wait_now     = RST_INIT_BACKOFF;
			fail_count   = 0;
			results_seen = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
			case (idx)
				REG_PING_INTERVAL:  ping_gap     = value[IVL_W-1:0];
				REG_DETECT_TIMEOUT: search_limit = value;
				REG_STALE:          quiet_limit  = value;
				REG_PROBE_WINDOW:   grace        = value;
				REG_INIT_BACKOFF:   first_wait   = value;
				REG_MAX_BACKOFF:    wait_cap     = value;
				default: ;
			endcase
		endfunction

		function void enter(logic [MODE_W-1:0] next, logic [TIME_W-1:0] stamp);
			mode  = next;
			since = stamp;
			if (next == MODE_SEARCHING)
				pings = '0;
			if (next == MODE_LINKED) begin
				retries  = '0;
				wait_now = first_wait;
			end
		endfunction

		// Advances the link state by one event and queues the result it causes.
		function void take_event(logic [KIND_W-1:0] kind, logic [TIME_W-1:0] stamp);
			lhs_result_t       due;
			logic [TIME_W-1:0] span;
			logic [TIME_W-1:0] gap_wide;
			logic [TIME_W:0]   wide;
			due      = '0;
			gap_wide = {{(TIME_W-IVL_W){1'b0}}, ping_gap};
			if (kind == KIND_BYTE || kind == KIND_PONG)
				heard_at = stamp;
			if (kind == KIND_PONG && (mode == MODE_SEARCHING || mode == MODE_ERROR)) begin
				enter(MODE_LINKED, stamp);
				due.just_linked = 1'b1;
			end
			case (mode)
				MODE_SEARCHING: begin
					span = stamp - ping_at;
					if (span >= gap_wide) begin
						due.send_ping = 1'b1;
						ping_at = stamp;
						pings = pings + 1'b1;
					end
					span = stamp - since;
					if (span >= search_limit)
						enter(MODE_ERROR, stamp);
				end
				MODE_LINKED: begin
					span = stamp - heard_at;
					if (span >= quiet_limit) begin
						due.send_ping = 1'b1;
						ping_at = stamp;
						// The drop threshold keeps its carry, so it can lie out of reach.
						wide = {1'b0, quiet_limit} + {1'b0, grace};
						if ({1'b0, span} >= wide)
							enter(MODE_SEARCHING, stamp);
					end
				end
				MODE_ERROR: begin
					span = stamp - since;
					if (span >= wait_now) begin
						retries = retries + 1'b1;
						wide = {wait_now, 1'b0};
						if (wide > {1'b0, wait_cap})
							wide = {1'b0, wait_cap};
						wait_now = wide[TIME_W-1:0];
						enter(MODE_SEARCHING, stamp);
					end
				end
				default: ;
			endcase
			due.link_state  = mode;
			due.ping_count  = pings;
			due.retry_count = retries;
			reports_due.push_back(due);
		endfunction

		function void check_report(logic [OUT_TDATA_W-1:0] word);
			lhs_result_t                     want;
			lhs_result_t                     got;
			logic [OUT_TDATA_W-REPORT_W-1:0] pad;
			results_seen++;
			if (reports_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("result %0d arrived with no event pending: %h", results_seen, word);
				return;
			end
			want = reports_due.pop_front();
			got  = word[REPORT_W-1:0];
			pad  = word[OUT_TDATA_W-1:REPORT_W];
			if (got.send_ping !== want.send_ping || got.link_state !== want.link_state ||
					got.ping_count !== want.ping_count || got.retry_count !== want.retry_count ||
					got.just_linked !== want.just_linked || pad !== '0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("result %0d differs: want ping %0d state %0d pings %0d retries %0d linked %0d",
						results_seen, want.send_ping, want.link_state, want.ping_count,
						want.retry_count, want.just_linked);
					$display("  got ping %0d state %0d pings %0d retries %0d linked %0d pad %h",
						got.send_ping, got.link_state, got.ping_count, got.retry_count,
						got.just_linked, pad);
				end
			end
		endfunction

		function int pending();
			return reports_due.size();
		endfunction

	endclass

endpackage

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// Link heartbeat supervisor testbench
// Drives timestamped tick, byte and pong events into the supervisor under a
// series of register settings, tracks the link state alongside it, and checks
// every result item in order with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb;

	import lhs_pkg::*;
	import link_tracker_pkg::*;

	// The spare kind code is handled as a tick; indexes six and seven are unused.
	localparam logic [KIND_W-1:0]    KIND_SPARE    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;

	localparam int unsigned MAX_GAP        = 17;
	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned DRAIN_SLACK    = 6;
	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned PHASES         = 10;
	localparam int unsigned PHASE_ITEMS    = 62;
	localparam int unsigned HOLD_PHASE     = 3;
	localparam int unsigned PAUSE_PHASE    = 6;

	// Time scale of each random phase: registers and timestamp steps are drawn
	// around it, so thresholds are met often whatever their size.
	localparam int unsigned PHASE_SCALE [PHASES] = '{
		3, 40, 2000, 200000, 32'h8000_0000, 12, 500, 40000, 5, 2000000
	};

	logic                    clk = 1'b0;
	logic                    arst_n;

	logic                    s_axis_tvalid;
	logic                    s_axis_tready;
	logic [TIME_W-1:0]       s_axis_tdata;   // now_ms [31:0]
	logic [KIND_W-1:0]       s_axis_tuser;   // kind [1:0]

	logic                    m_axis_tvalid;
	logic                    m_axis_tready;
	// send_ping [0], link_state [2:1], ping_count [10:3], retry_count [18:11],
	// just_linked [19], zero [23:20]
	logic [OUT_TDATA_W-1:0]  m_axis_tdata;

	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [TIME_W-1:0]       cfg_data;

	link_tracker             tracker;
	bit                      tx_burst = 1'b0;
	bit                      rx_burst = 1'b0;
	bit                      hold_req = 1'b0;
	logic [TIME_W-1:0]       clock_ms;
	int unsigned             quiet_cycles = 0;

	link_heartbeat_supervisor_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The watchdog ends a run that has stopped moving: any cycle without an
	// accepted event, result or register write counts toward the limit.
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side. Before each item the receiver draws a stall; when asked it
	// instead holds off for a long stretch so that the block fills up and
	// stalls its event input. All signals are sampled just after the edge, so
	// they hold the values that the edge itself saw.
	initial begin
		int unsigned gap;
		m_axis_tready <= 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				gap = LONG_HOLD;
			end else if (rx_burst) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, MAX_GAP);
			end
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do
				@(posedge clk);
			while (!(m_axis_tvalid && m_axis_tready));
			tracker.check_report(m_axis_tdata);
		end
	end

	// Offers one event item after a random gap and notes it once accepted.
	// Valid stays high on return, so a back-to-back item never drops it.
	task automatic send_event(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] stamp);
		int unsigned gap;
		gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= stamp;
		s_axis_tuser  <= kind;
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		tracker.take_event(kind, stamp);
	endtask

	// Writes one register and leaves the channel's valid high for the caller.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		tracker.write_reg(idx, value);
	endtask

	task automatic load_config(input logic [TIME_W-1:0] ping_ivl, input logic [TIME_W-1:0] detect,
			input logic [TIME_W-1:0] stale, input logic [TIME_W-1:0] window,
			input logic [TIME_W-1:0] first_wait, input logic [TIME_W-1:0] wait_cap);
		write_reg(REG_PING_INTERVAL, ping_ivl);
		write_reg(REG_DETECT_TIMEOUT, detect);
		write_reg(REG_STALE, stale);
		write_reg(REG_PROBE_WINDOW, window);
		write_reg(REG_INIT_BACKOFF, first_wait);
		write_reg(REG_MAX_BACKOFF, wait_cap);
		cfg_valid <= 1'b0;
	endtask

	// Stops offering events and waits until every expected result has come,
	// then lets the pipeline settle before anything else happens.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Register values: mostly near the phase scale, with zero, one and all ones
	// mixed in. The ping interval register keeps only its low bits.
	function automatic logic [TIME_W-1:0] pick_limit(input int unsigned scale);
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r == 2)
			return 1;
		return $urandom_range(1, scale);
	endfunction

	task automatic run_directed();
		// Reset settings: ping every 2000, error after 30000 searching, probe
		// after 15000 quiet, drop 3000 later, backoff 5000 capped at 30000.
		send_event(KIND_TICK, 32'd0);          // nothing due at time zero
		send_event(KIND_TICK, 32'd2000);       // ping exactly on the interval
		send_event(KIND_BYTE, 32'd2500);       // a byte while searching only logs time
		send_event(KIND_SPARE, 32'd4000);      // the spare kind acts as a tick
		send_event(KIND_TICK, 32'd30000);      // ping and detect timeout at once
		send_event(KIND_TICK, 32'd35000);      // backoff served, search again
		send_event(KIND_PONG, 32'd36000);      // pong links
		send_event(KIND_PONG, 32'd37000);      // pong while linked refreshes only
		send_event(KIND_TICK, 32'd52000);      // stale: probe without counting it
		send_event(KIND_TICK, 32'd55000);      // probe window over: drop
		send_event(KIND_TICK, 32'hFFFF_FFF0);  // long search ends in error
		send_event(KIND_PONG, 32'h0000_0010);  // pong from error, time wrapped
		send_event(KIND_TICK, 32'h0000_3AA0);  // quiet stays just short of stale
		wait_drained();

		// Tightest timing with the widest interval, and a backoff large enough
		// that doubling it needs the carry before the cap applies.
		load_config(32'h0000_FFFF, 32'd1, 32'd1, 32'd0, 32'hC000_0000, 32'hFFFF_FFFF);
		clock_ms = 32'h0000_3AA5;
		send_event(KIND_TICK, clock_ms);                  // probe and drop together
		send_event(KIND_TICK, clock_ms + 32'd1);          // search gives up at once
		send_event(KIND_PONG, clock_ms + 32'd2);          // link loads the large backoff
		send_event(KIND_TICK, clock_ms + 32'd3);          // dropped again
		send_event(KIND_TICK, clock_ms + 32'd4);          // into error
		clock_ms = clock_ms + 32'hC000_0004;
		send_event(KIND_TICK, clock_ms);                  // doubled backoff hits the cap
		send_event(KIND_TICK, clock_ms + 32'd1);          // back into error
		wait_drained();

		// Zero in every register: each threshold is met at once. The unused
		// indexes are written too and must change nothing.
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'h5A5A_A5A5);
		load_config('0, '0, '0, '0, '0, '0);
		clock_ms = clock_ms + 32'd7;
		send_event(KIND_TICK, clock_ms);       // capped backoff still pending
		send_event(KIND_PONG, clock_ms);       // link, probe and drop in one event
		send_event(KIND_TICK, clock_ms);       // ping, then error at once
		send_event(KIND_TICK, clock_ms);       // zero backoff doubles to zero
		wait_drained();

		// Stale plus window overflows 32 bits, so a linked link never drops.
		load_config(32'd1, '1, '1, '1, 32'd1, 32'd1);
		send_event(KIND_PONG, clock_ms);
		send_event(KIND_TICK, clock_ms - 32'd1);
	endtask

	// One random phase: fresh registers, then a mix of ticks, bytes, pongs and
	// spare kinds whose timestamps step by up to the scale, with now and then
	// a jump anywhere or a repeated timestamp.
	task automatic run_random_phase(input int unsigned scale, input bit hold, input bit pause);
		int unsigned       pong_pct;
		int unsigned       r;
		logic [KIND_W-1:0] kind;
		wait_drained();
		load_config(pick_limit(scale), pick_limit(scale), pick_limit(scale), pick_limit(scale),
			pick_limit(scale), pick_limit(scale));
		pong_pct = $urandom_range(1, 30);
		tx_burst = hold || ($urandom_range(0, 3) == 0);
		rx_burst = !hold && ($urandom_range(0, 3) == 0);
		if (hold)
			hold_req = 1'b1;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			// Once in the run the sender waits for every result mid-phase.
			if (pause && i == PHASE_ITEMS / 2)
				wait_drained();
			if (!hold && i % 16 == 15) begin
				tx_burst = ($urandom_range(0, 3) == 0);
				rx_burst = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < pong_pct)
				kind = KIND_PONG;
			else if (r < pong_pct + 25)
				kind = KIND_BYTE;
			else if (r < pong_pct + 32)
				kind = KIND_SPARE;
			else
				kind = KIND_TICK;
			r = $urandom_range(0, 19);
			if (r == 0)
				clock_ms = $urandom();
			else if (r > 1)
				clock_ms = clock_ms + $urandom_range(0, scale);
			send_event(kind, clock_ms);
		end
	endtask

	initial begin
		tracker = new();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= KIND_TICK;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_PING_INTERVAL;
		cfg_data      <= '0;
		clock_ms      = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		for (int p = 0; p < PHASES; p++)
			run_random_phase(PHASE_SCALE[p], p == HOLD_PHASE, p == PAUSE_PHASE);

		wait_drained();
		if (tracker.fail_count == 0 && tracker.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
